// ===== rtl/monge_ampere_stencil_residual_defines.svh =====
// Assertion macros used by the checker file of the stencil residual block.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef MONGE_AMPERE_STENCIL_RESIDUAL_DEFINES_SVH
`define MONGE_AMPERE_STENCIL_RESIDUAL_DEFINES_SVH

// Clocked assertion, idle while reset is high
`define MAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define MAS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/mas_pkg.sv =====
// Shared constants for the Monge-Ampere stencil residual block.
// Depends on nothing; used by the top level and its submodules.
package mas_pkg;

   // Configuration register width and index width
   localparam int REG_BITS = 47;
   localparam int CSR_IDX_BITS = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_EPSILON   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_HX_SQ = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_HY_SQ = 2'd2;

   // Register reset values, unsigned Q23.24
   localparam logic [REG_BITS-1:0] EPSILON_RESET = 47'd16777;
   localparam logic [REG_BITS-1:0] INV_H_SQ_RESET = 47'h1_0000_0000;

   // Stage control carried next to each item
   typedef struct packed {
      logic valid;
   } stage_ctl_type;

endpackage

// ===== rtl/monge_ampere_stencil_residual.sv =====
// The divider resolves one quotient bit per stage.
// Throughput: one point per cycle; a stalled result holds every stage in place.
// Reset: synchronous, active high; clears all valid bits and loads the register defaults.
// Top level of the 2D Monge-Ampere residual pipeline; depends on mas_pkg, mas_mul and
// mas_div_step.
module monge_ampere_stencil_residual #(
   parameter int FRAC_BITS = 24,
   parameter int WORD_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [mas_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mas_pkg::REG_BITS-1:0]        csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_is_boundary,
   input  logic signed [WORD_BITS-1:0]         req_u_center,
   input  logic signed [WORD_BITS-1:0]         req_u_north,
   input  logic signed [WORD_BITS-1:0]         req_u_south,
   input  logic signed [WORD_BITS-1:0]         req_u_east,
   input  logic signed [WORD_BITS-1:0]         req_u_west,
   input  logic signed [WORD_BITS-1:0]         req_rhs_value,
   input  logic signed [WORD_BITS-1:0]         req_bdry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [WORD_BITS-1:0]         rsp_residual,
   output logic                                rsp_saturated
);
   localparam int W   = WORD_BITS;
   localparam int RB  = mas_pkg::REG_BITS;
   localparam int SW  = W + 2;
   localparam int PRW = SW + RB;
   localparam int SHW = PRW - FRAC_BITS;
   localparam int MB  = (W - 1 > RB) ? W - 1 : RB;
   localparam int QB  = MB + 1;
   localparam int LW  = 2 * QB - FRAC_BITS;

   typedef struct packed {
      logic signed [W-1:0] rhs;
      logic signed [W:0]   bd;
      logic                bnd;
   } front_type;

   typedef struct packed {
      logic signed [W-1:0] rhs;
      logic signed [W-1:0] right;
      logic signed [W:0]   bd;
      logic                bnd;
      logic                sat;
   } back_type;

   localparam int FW = $bits(front_type);
   localparam int BKW = $bits(back_type);

   logic adv;

   // Configuration registers
   logic [RB-1:0] eps_ff, inv_hx_ff, inv_hy_ff;

   // Front stages
   logic v1_ff, v2_ff, v5_ff, v6_ff, v7_ff, va_ff, vb_ff, rsp_valid_ff;
   logic signed [SW-1:0] sh1_ff, sh1_in, sv1_ff, sv1_in;
   front_type fr1_ff, fr1_in, fr2_ff, fr4, fr5_ff, fr6_ff;
   logic [SW-1:0] mag_h2_ff, mag_h_in, mag_v2_ff, mag_v_in;
   logic neg_h2_ff, neg_v2_ff, neg_h4, neg_v4;
   mas_pkg::stage_ctl_type ctl2, ctl4;
   logic [PRW-1:0] prod_h4, prod_v4;
   logic signed [SHW:0] dh5_ff, dh5_in, dv5_ff, dv5_in;
   logic signed [W-1:0] dh6_ff, dh6_in, dv6_ff, dv6_in;
   logic sat6_ff, sat6_in, ovf_h, ovf_v;

   // Floor and minimum stage
   logic [MB-1:0] mh7_ff, mh7_in, mv7_ff, mv7_in, mh_raw, mv_raw;
   logic gt_h, gt_v;
   logic signed [MB:0] eps_s, dh_s, dv_s, min1, min2;
   back_type bk7_ff, bk7_in, bk9, bka_ff, bkq;
   mas_pkg::stage_ctl_type ctl7, ctl9, ctlq, ctlh;
   logic [MB:0] dsum7;
   logic [2*MB-1:0] num9;
   logic [MB:0] dsum9;

   // Divider chain
   mas_pkg::stage_ctl_type div_ctl [QB+1];
   logic [QB-1:0] div_rem [QB+1];
   logic [QB-1:0] div_qn  [QB+1];
   logic [QB-1:0] div_d   [QB+1];
   logic [BKW-1:0] div_pay [QB+1];

   // Back stages
   logic [2*QB-1:0] hh_prod;
   back_type hh_pay;
   logic signed [LW+1:0] lr_a_ff, lr_a_in;
   logic signed [LW+2:0] r_b_ff, r_b_in;
   logic sat_b_ff, sat_b_in, ovf_r;
   logic signed [W-1:0] rsp_residual_ff, rsp_residual_in;
   logic rsp_saturated_ff, rsp_saturated_in;

   // Stall the whole pipe while the result waits
   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= mas_pkg::EPSILON_RESET;
         inv_hx_ff <= mas_pkg::INV_H_SQ_RESET;
         inv_hy_ff <= mas_pkg::INV_H_SQ_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mas_pkg::CSR_EPSILON:   eps_ff    <= csr_wdata;
            mas_pkg::CSR_INV_HX_SQ: inv_hx_ff <= csr_wdata;
            mas_pkg::CSR_INV_HY_SQ: inv_hy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: stencil sums and boundary difference
   always_comb begin
      sh1_in = SW'(req_u_west) + SW'(req_u_east) - (SW'(req_u_center) <<< 1);
      sv1_in = SW'(req_u_north) + SW'(req_u_south) - (SW'(req_u_center) <<< 1);
      fr1_in.rhs = req_rhs_value;
      fr1_in.bd  = (W+1)'(req_u_center) - (W+1)'(req_bdry_value);
      fr1_in.bnd = req_is_boundary;
   end

   // Stage 2: split sign and magnitude
   assign mag_h_in = sh1_ff[SW-1] ? SW'(-sh1_ff) : SW'(sh1_ff);
   assign mag_v_in = sv1_ff[SW-1] ? SW'(-sv1_ff) : SW'(sv1_ff);
   assign ctl2.valid = v2_ff;

   // Stages 3 and 4: scale by the reciprocal squared spacings
   mas_mul #(.AW(SW), .BW(RB), .PW(FW + 1)) u_mul_h (
      .clock(clock), .reset(reset), .en(adv),
      .in_ctl(ctl2), .in_a(mag_h2_ff), .in_b(inv_hx_ff), .in_pay({neg_h2_ff, fr2_ff}),
      .out_ctl(ctl4), .out_prod(prod_h4), .out_pay({neg_h4, fr4})
   );

   mas_mul #(.AW(SW), .BW(RB), .PW(1)) u_mul_v (
      .clock(clock), .reset(reset), .en(adv),
      .in_ctl(ctl2), .in_a(mag_v2_ff), .in_b(inv_hy_ff), .in_pay(neg_v2_ff),
      .out_ctl(), .out_prod(prod_v4), .out_pay(neg_v4)
   );

   // Stage 5: drop fraction bits and restore sign
   assign dh5_in = neg_h4 ? -$signed({1'b0, prod_h4[PRW-1:FRAC_BITS]})
                          :  $signed({1'b0, prod_h4[PRW-1:FRAC_BITS]});
   assign dv5_in = neg_v4 ? -$signed({1'b0, prod_v4[PRW-1:FRAC_BITS]})
                          :  $signed({1'b0, prod_v4[PRW-1:FRAC_BITS]});

   // Stage 6: clip second differences to the word range
   always_comb begin
      ovf_h = dh5_ff[SHW:W-1] != {(SHW-W+2){dh5_ff[SHW]}};
      ovf_v = dv5_ff[SHW:W-1] != {(SHW-W+2){dv5_ff[SHW]}};
      if (ovf_h) begin
         dh6_in = dh5_ff[SHW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         dh6_in = dh5_ff[W-1:0];
      end
      if (ovf_v) begin
         dv6_in = dv5_ff[SHW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         dv6_in = dv5_ff[W-1:0];
      end
      sat6_in = ovf_h || ovf_v;
   end

   // Stage 7: floor at epsilon and take the minimum term
   always_comb begin
      gt_h   = !dh6_ff[W-1] && (MB'(dh6_ff[W-2:0]) > MB'(eps_ff));
      gt_v   = !dv6_ff[W-1] && (MB'(dv6_ff[W-2:0]) > MB'(eps_ff));
      mh_raw = gt_h ? MB'(dh6_ff[W-2:0]) : MB'(eps_ff);
      mv_raw = gt_v ? MB'(dv6_ff[W-2:0]) : MB'(eps_ff);
      mh7_in = (mh_raw == '0) ? MB'(1) : mh_raw;
      mv7_in = (mv_raw == '0) ? MB'(1) : mv_raw;
      eps_s  = $signed({1'b0, MB'(eps_ff)});
      dh_s   = (MB+1)'(dh6_ff);
      dv_s   = (MB+1)'(dv6_ff);
      min1   = (dh_s < eps_s) ? dh_s : eps_s;
      min2   = (dv_s < min1) ? dv_s : min1;
      bk7_in.rhs   = fr6_ff.rhs;
      bk7_in.right = min2[W-1:0];
      bk7_in.bd    = fr6_ff.bd;
      bk7_in.bnd   = fr6_ff.bnd;
      bk7_in.sat   = sat6_ff;
   end

   // Stages 8 and 9: product of the floored differences, sum in the payload
   assign ctl7.valid = v7_ff;
   assign dsum7 = (MB+1)'(mh7_ff) + (MB+1)'(mv7_ff);

   mas_mul #(.AW(MB), .BW(MB), .PW(MB + 1 + BKW)) u_mul_n (
      .clock(clock), .reset(reset), .en(adv),
      .in_ctl(ctl7), .in_a(mh7_ff), .in_b(mv7_ff), .in_pay({dsum7, bk7_ff}),
      .out_ctl(ctl9), .out_prod(num9), .out_pay({dsum9, bk9})
   );

   // Divide 2*mh*mv by mh+mv, one quotient bit per stage
   assign div_ctl[0] = ctl9;
   assign div_rem[0] = {1'b0, num9[2*MB-1:MB]};
   assign div_qn[0]  = {num9[MB-1:0], 1'b0};
   assign div_d[0]   = dsum9;
   assign div_pay[0] = bk9;

   for (genvar i = 0; i < QB; i++) begin : g_div
      mas_div_step #(.DW(QB), .PW(BKW)) u_step (
         .clock(clock), .reset(reset), .en(adv),
         .in_ctl(div_ctl[i]), .in_rem(div_rem[i]), .in_qn(div_qn[i]),
         .in_div(div_d[i]), .in_pay(div_pay[i]),
         .out_ctl(div_ctl[i+1]), .out_rem(div_rem[i+1]), .out_qn(div_qn[i+1]),
         .out_div(div_d[i+1]), .out_pay(div_pay[i+1])
      );
   end

   assign ctlq = div_ctl[QB];
   assign bkq  = div_pay[QB];

   // Square the harmonic mean
   mas_mul #(.AW(QB), .BW(QB), .PW(BKW)) u_mul_hh (
      .clock(clock), .reset(reset), .en(adv),
      .in_ctl(ctlq), .in_a(div_qn[QB]), .in_b(div_qn[QB]), .in_pay(bkq),
      .out_ctl(ctlh), .out_prod(hh_prod), .out_pay(hh_pay)
   );

   // Stage A: left plus right
   assign lr_a_in = $signed({2'b00, hh_prod[2*QB-1:FRAC_BITS]}) + (LW+2)'(hh_pay.right);

   // Stage B: residual before clipping
   always_comb begin
      if (bka_ff.bnd) begin
         r_b_in = (LW+3)'(bka_ff.bd);
      end else begin
         r_b_in = (LW+3)'(bka_ff.rhs) - (LW+3)'(lr_a_ff);
      end
      sat_b_in = bka_ff.sat && !bka_ff.bnd;
   end

   // Output stage: clip residual and merge the flags
   always_comb begin
      ovf_r = r_b_ff[LW+2:W-1] != {(LW-W+4){r_b_ff[LW+2]}};
      if (ovf_r) begin
         rsp_residual_in = r_b_ff[LW+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         rsp_residual_in = r_b_ff[W-1:0];
      end
      rsp_saturated_in = ovf_r || sat_b_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v5_ff        <= ctl4.valid;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         va_ff        <= ctlh.valid;
         vb_ff        <= va_ff;
         rsp_valid_ff <= vb_ff;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (adv) begin
         sh1_ff           <= sh1_in;
         sv1_ff           <= sv1_in;
         fr1_ff           <= fr1_in;
         mag_h2_ff        <= mag_h_in;
         mag_v2_ff        <= mag_v_in;
         neg_h2_ff        <= sh1_ff[SW-1];
         neg_v2_ff        <= sv1_ff[SW-1];
         fr2_ff           <= fr1_ff;
         dh5_ff           <= dh5_in;
         dv5_ff           <= dv5_in;
         fr5_ff           <= fr4;
         dh6_ff           <= dh6_in;
         dv6_ff           <= dv6_in;
         sat6_ff          <= sat6_in;
         fr6_ff           <= fr5_ff;
         mh7_ff           <= mh7_in;
         mv7_ff           <= mv7_in;
         bk7_ff           <= bk7_in;
         lr_a_ff          <= lr_a_in;
         bka_ff           <= hh_pay;
         r_b_ff           <= r_b_in;
         sat_b_ff         <= sat_b_in;
         rsp_residual_ff  <= rsp_residual_in;
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_residual  = rsp_residual_ff;
   assign rsp_saturated = rsp_saturated_ff;
endmodule

// ===== rtl/mas_mul.sv =====
// Two-stage unsigned multiplier built from four registered partial products.
// Carries a side payload with the same latency. Depends on mas_pkg.
module mas_mul #(
   parameter int AW = 48,
   parameter int BW = 48,
   parameter int PW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  mas_pkg::stage_ctl_type in_ctl,
   input  logic [AW-1:0]         in_a,
   input  logic [BW-1:0]         in_b,
   input  logic [PW-1:0]         in_pay,
   output mas_pkg::stage_ctl_type out_ctl,
   output logic [AW+BW-1:0]      out_prod,
   output logic [PW-1:0]         out_pay
);
   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;

   mas_pkg::stage_ctl_type ctl1_ff, ctl2_ff;
   logic [AL+BL-1:0] pp_ll_ff, pp_ll_in;
   logic [AL+BH-1:0] pp_lh_ff, pp_lh_in;
   logic [AH+BL-1:0] pp_hl_ff, pp_hl_in;
   logic [AH+BH-1:0] pp_hh_ff, pp_hh_in;
   logic [PW-1:0]    pay1_ff, pay2_ff;
   logic [AW+BW-1:0] prod_ff, prod_in;

   // Form the partial products
   assign pp_ll_in = in_a[AL-1:0] * in_b[BL-1:0];
   assign pp_lh_in = in_a[AL-1:0] * in_b[BW-1:BL];
   assign pp_hl_in = in_a[AW-1:AL] * in_b[BL-1:0];
   assign pp_hh_in = in_a[AW-1:AL] * in_b[BW-1:BL];

   // Sum the partial products at their weights
   assign prod_in = (AW+BW)'(pp_ll_ff)
                  + ((AW+BW)'(pp_lh_ff) << BL)
                  + ((AW+BW)'(pp_hl_ff) << AL)
                  + ((AW+BW)'(pp_hh_ff) << (AL+BL));

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (en) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         pay1_ff  <= in_pay;
         prod_ff  <= prod_in;
         pay2_ff  <= pay1_ff;
      end
   end

   assign out_ctl  = ctl2_ff;
   assign out_prod = prod_ff;
   assign out_pay  = pay2_ff;
endmodule

// ===== rtl/mas_div_step.sv =====
// One registered step of a restoring divider: one quotient bit per stage.
// The quotient shifts in where the numerator bits shift out. Depends on mas_pkg.
module mas_div_step #(
   parameter int DW = 48,
   parameter int PW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  mas_pkg::stage_ctl_type in_ctl,
   input  logic [DW-1:0]         in_rem,
   input  logic [DW-1:0]         in_qn,
   input  logic [DW-1:0]         in_div,
   input  logic [PW-1:0]         in_pay,
   output mas_pkg::stage_ctl_type out_ctl,
   output logic [DW-1:0]         out_rem,
   output logic [DW-1:0]         out_qn,
   output logic [DW-1:0]         out_div,
   output logic [PW-1:0]         out_pay
);
   mas_pkg::stage_ctl_type ctl_ff;
   logic [DW-1:0] rem_ff, rem_in, qn_ff, qn_in, div_ff;
   logic [PW-1:0] pay_ff;
   logic [DW:0]   trial;
   logic [DW+1:0] diff;
   logic          take;

   // Shift in the next numerator bit and subtract where it fits
   always_comb begin
      trial  = {in_rem, in_qn[DW-1]};
      diff   = {1'b0, trial} - {2'b00, in_div};
      take   = !diff[DW+1];
      rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      qn_in  = {in_qn[DW-2:0], take};
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= in_ctl;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         qn_ff  <= qn_in;
         div_ff <= in_div;
         pay_ff <= in_pay;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_rem = rem_ff;
   assign out_qn  = qn_ff;
   assign out_div = div_ff;
   assign out_pay = pay_ff;
endmodule

// ===== rtl/mas_checker.sv =====
// Port-level checks for the stencil residual block, bound to the top level.
// Depends on monge_ampere_stencil_residual_defines.svh.
`include "monge_ampere_stencil_residual_defines.svh"

module mas_checker #(
   parameter int WORD_BITS = 48
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WORD_BITS-1:0] rsp_residual,
   input logic                        rsp_saturated
);
   // A stalled result holds
   `MAS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residual) && $stable(rsp_saturated), "result changed while stalled")

   // Input is taken exactly when the result side can move
   `MAS_ASSERT(a_ready_follows, req_ready == (!rsp_valid || rsp_ready), "input ready does not track result stall")

   // No result right after reset
   `MAS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")
endmodule

bind monge_ampere_stencil_residual mas_checker #(.WORD_BITS(WORD_BITS)) u_mas_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_residual(rsp_residual),
   .rsp_saturated(rsp_saturated)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the Monge-Ampere stencil residual pipeline.
// Depends on mas_pkg and monge_ampere_stencil_residual; predicts each residual in place unless a directed row gives it.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 24;
   localparam int WORD = 48;
   localparam int RUN_LIMIT = 400000;
   localparam int PHASE_POINTS = 365;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [mas_pkg::CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic [mas_pkg::REG_BITS-1:0] REG_MAX = {mas_pkg::REG_BITS{1'b1}};
   localparam logic signed [127:0] WORD_MAX = (128'sd1 <<< (WORD-1)) - 1;
   localparam logic signed [127:0] WORD_MIN = -(128'sd1 <<< (WORD-1));
   localparam logic signed [WORD-1:0] W_MAX = {1'b0, {(WORD-1){1'b1}}};
   localparam logic signed [WORD-1:0] W_MIN = {1'b1, {(WORD-1){1'b0}}};

   typedef struct {
      logic                   is_boundary;
      logic signed [WORD-1:0] u_center, u_north, u_south, u_east, u_west;
      logic signed [WORD-1:0] rhs_value, bdry_value;
   } point_type;

   typedef struct {
      logic signed [WORD-1:0] residual;
      logic                   saturated;
   } residual_type;

   typedef struct {
      point_type    pt;
      bit           typed;
      residual_type res;
   } stim_row_type;

   logic clock, reset;
   logic csr_write;
   logic [mas_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [mas_pkg::REG_BITS-1:0] csr_wdata;
   logic req_valid, req_ready, req_is_boundary;
   logic signed [WORD-1:0] req_u_center, req_u_north, req_u_south, req_u_east, req_u_west;
   logic signed [WORD-1:0] req_rhs_value, req_bdry_value;
   logic rsp_valid, rsp_ready, rsp_saturated;
   logic signed [WORD-1:0] rsp_residual;

   // predictor copy of the registers
   logic [mas_pkg::REG_BITS-1:0] epsilon_q, inv_hx_q, inv_hy_q;

   residual_type expected_residuals[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet = 0;
   bit  long_hold = 0;

   monge_ampere_stencil_residual #(.FRAC_BITS(FRAC), .WORD_BITS(WORD)) u_top (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [127:0] clip_word(logic signed [127:0] a, ref logic hit);
      if (a > WORD_MAX) begin
         hit = 1;
         return WORD_MAX;
      end
      if (a < WORD_MIN) begin
         hit = 1;
         return WORD_MIN;
      end
      return a;
   endfunction

   // scale a raw difference sum by 1/h^2, truncating toward zero
   function automatic logic signed [127:0] scale_diff(logic signed [127:0] s,
                                                     logic [mas_pkg::REG_BITS-1:0] inv,
                                                     ref logic hit);
      logic signed [127:0] mag, prod;
      mag = (s < 0) ? -s : s;
      prod = (mag * $signed({81'b0, inv})) >>> FRAC;
      if (s < 0) prod = -prod;
      return clip_word(prod, hit);
   endfunction

   function automatic logic signed [127:0] floor_eps(logic signed [127:0] d);
      logic signed [127:0] m;
      m = $signed({81'b0, epsilon_q});
      if (d > m) m = d;
      if (m == 0) m = 1;
      return m;
   endfunction

   function automatic residual_type predict_residual(point_type p);
      logic signed [127:0] uc, dh, dv, mh, mv, h, left, right, r;
      logic hit;
      residual_type res;
      hit = 0;
      uc = p.u_center;
      if (p.is_boundary) begin
         r = uc - p.bdry_value;
      end else begin
         dh = scale_diff(p.u_west + 128'sd0 + p.u_east - 2 * uc, inv_hx_q, hit);
         dv = scale_diff(p.u_north + 128'sd0 + p.u_south - 2 * uc, inv_hy_q, hit);
         mh = floor_eps(dh);
         mv = floor_eps(dv);
         // harmonic-mean form of the quadrature
         h = (2 * mh * mv) / (mh + mv);
         left = (h * h) >>> FRAC;
         right = $signed({81'b0, epsilon_q});
         if (dh < right) right = dh;
         if (dv < right) right = dv;
         r = p.rhs_value - (left + right);
      end
      r = clip_word(r, hit);
      res.residual = r[WORD-1:0];
      res.saturated = hit;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic signed [WORD-1:0] rand_word(int kind);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case (kind)
         0: return raw[WORD-1:0];
         1: begin
            case ($urandom_range(0, 4))
               0: return W_MAX;
               1: return W_MIN;
               2: return '0;
               3: return '1;
               default: return 1;
            endcase
         end
         default: begin
            // small signed value, magnitude below 2^k for a random k up to 34
            raw = raw & ((64'd1 << $urandom_range(0, 34)) - 1);
            return raw[0] ? -$signed(raw[WORD-1:0]) : $signed(raw[WORD-1:0]);
         end
      endcase
   endfunction

   function automatic point_type rand_point();
      point_type p;
      int kind;
      kind = $urandom_range(0, 9);
      p.is_boundary = (kind < 2);
      p.u_center = rand_word(kind == 1 ? 2 : (kind == 3 ? 1 : 0));
      p.bdry_value = rand_word(kind == 1 ? 2 : (kind == 3 ? 1 : 0));
      p.rhs_value = rand_word($urandom_range(0, 2));
      if (kind >= 5) begin
         // smooth neighborhood: neighbors close to the center
         p.u_center = rand_word(2);
         p.u_north = p.u_center + rand_word(2);
         p.u_south = p.u_center + rand_word(2);
         p.u_east = p.u_center + rand_word(2);
         p.u_west = p.u_center + rand_word(2);
      end else begin
         p.u_north = rand_word(kind == 3 ? 1 : 0);
         p.u_south = rand_word(kind == 3 ? 1 : 0);
         p.u_east = rand_word(kind == 3 ? 1 : 0);
         p.u_west = rand_word(kind == 3 ? 1 : 0);
      end
      return p;
   endfunction

   function automatic stim_row_type make_row(logic bnd, logic signed [WORD-1:0] c, n, s, e, w,
                                             rhs, g, bit typed, logic signed [WORD-1:0] res,
                                             logic sat);
      stim_row_type row;
      row.pt = '{bnd, c, n, s, e, w, rhs, g};
      row.typed = typed;
      row.res = '{res, sat};
      return row;
   endfunction

   // offer one point and hold it until the transfer
   task automatic send_point(point_type p, bit typed, residual_type typed_res);
      req_valid <= 1;
      req_is_boundary <= p.is_boundary;
      req_u_center <= p.u_center;
      req_u_north <= p.u_north;
      req_u_south <= p.u_south;
      req_u_east <= p.u_east;
      req_u_west <= p.u_west;
      req_rhs_value <= p.rhs_value;
      req_bdry_value <= p.bdry_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_residuals.push_back(typed ? typed_res : predict_residual(p));
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // one write, then a quiet cycle so back-to-back writes never collide
   task automatic write_reg(logic [mas_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [mas_pkg::REG_BITS-1:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         mas_pkg::CSR_EPSILON:   epsilon_q = value;
         mas_pkg::CSR_INV_HX_SQ: inv_hx_q = value;
         mas_pkg::CSR_INV_HY_SQ: inv_hy_q = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drain the pipeline before touching the registers
   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (expected_residuals.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      stim_row_type table_rows[$];
      residual_type none;
      reset = 1;
      csr_write = 0;
      csr_index = mas_pkg::CSR_EPSILON;
      csr_wdata = '0;
      req_valid = 0;
      req_is_boundary = 0;
      req_u_center = '0;
      req_u_north = '0;
      req_u_south = '0;
      req_u_east = '0;
      req_u_west = '0;
      req_rhs_value = '0;
      req_bdry_value = '0;
      epsilon_q = mas_pkg::EPSILON_RESET;
      inv_hx_q = mas_pkg::INV_H_SQ_RESET;
      inv_hy_q = mas_pkg::INV_H_SQ_RESET;
      none = '{'0, 1'b0};
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed table under the reset registers
      table_rows.push_back(make_row(1, 48'sd5 <<< 24, 0, 0, 0, 0, 0, 48'sd2 <<< 24,
                                    1, 48'sd3 <<< 24, 0));
      table_rows.push_back(make_row(1, W_MAX, 0, 0, 0, 0, 0, W_MIN, 1, W_MAX, 1));
      table_rows.push_back(make_row(1, W_MIN, 0, 0, 0, 0, 0, W_MAX, 1, W_MIN, 1));
      table_rows.push_back(make_row(1, 0, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, 0, 1, 0, 0));
      // flat field: both differences at the floor, left = eps^2 >> 24 = 16
      table_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0, 1, -48'sd16, 0));
      table_rows.push_back(make_row(0, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 0, 0, 0, 0, 0, W_MIN, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 0, 0, 0, 0, 0, W_MAX, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 0, -1, -1, -1, -1, 0, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 48'sd1 <<< 24, 48'sd4 <<< 24, 0, 48'sd3 <<< 24, 0,
                                    48'sd7 <<< 24, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, 0, 48'sd1 <<< 20, 0, -48'sd1 <<< 20, 0, 0, 0, 0, 0, 0));
      table_rows.push_back(make_row(0, '1, '1, '1, '1, '1, '1, '1, 0, 0, 0));
      foreach (table_rows[i])
         send_point(table_rows[i].pt, table_rows[i].typed, table_rows[i].res);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: begin
                  // zero floor, extreme spacings
                  write_reg(mas_pkg::CSR_EPSILON, '0);
                  write_reg(mas_pkg::CSR_INV_HX_SQ, 47'd1);
                  write_reg(mas_pkg::CSR_INV_HY_SQ, REG_MAX);
               end
               2: begin
                  write_reg(mas_pkg::CSR_EPSILON, REG_MAX);
                  write_reg(mas_pkg::CSR_INV_HX_SQ, REG_MAX);
                  write_reg(mas_pkg::CSR_INV_HY_SQ, 47'd1);
                  long_hold = 1;
               end
               3: begin
                  write_reg(mas_pkg::CSR_EPSILON, 47'd1 << 20);
                  write_reg(mas_pkg::CSR_INV_HX_SQ, 47'd1 << 30);
                  write_reg(mas_pkg::CSR_INV_HY_SQ, 47'd1 << 34);
                  // unmapped index must leave the registers alone
                  write_reg(CSR_SPARE, 47'h2AAA_AAAA_AAAA);
               end
               default: begin
                  write_reg(mas_pkg::CSR_EPSILON, mas_pkg::EPSILON_RESET);
                  write_reg(mas_pkg::CSR_INV_HX_SQ, mas_pkg::INV_H_SQ_RESET);
                  write_reg(mas_pkg::CSR_INV_HY_SQ, mas_pkg::INV_H_SQ_RESET);
               end
            endcase
         end
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (phase == 4 && n > PHASE_POINTS - 150) quiet = 1;
            send_point(rand_point(), 0, none);
         end
      end

      // drain and settle
      req_valid <= 0;
      @(posedge clock);
      while (expected_residuals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- result side stalls
   initial begin
      rsp_ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            // hold off long enough to back the pipeline up into the input
            rsp_ready <= 0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------- result checking
   always @(posedge clock) begin
      residual_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_residuals.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            exp_res = expected_residuals.pop_front();
            if (rsp_residual !== exp_res.residual)
               report_mismatch($sformatf("residual got %0d want %0d",
                                         rsp_residual, exp_res.residual));
            if (rsp_saturated !== exp_res.saturated)
               report_mismatch($sformatf("saturated got %b want %b",
                                         rsp_saturated, exp_res.saturated));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mas_pkg.sv
rtl/mas_mul.sv
rtl/mas_div_step.sv
rtl/monge_ampere_stencil_residual.sv
rtl/mas_checker.sv
sim/testbench.sv
